// File: sv/crc_framed_packet_deframer_defines.svh
// Assertion macros shared by the deframer checker.
`ifndef CRC_FRAMED_PACKET_DEFRAMER_DEFINES_SVH
`define CRC_FRAMED_PACKET_DEFRAMER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define CRCFD_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("crcfd: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define CRCFD_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("crcfd: next-cycle check failed");

`endif

// File: sv/crcfd_pkg.sv
// Types, constants and CRC table for the CRC framed packet deframer.
`default_nettype none
package crcfd_pkg;

   localparam int unsigned MAX_FRAME_BYTES_DEFAULT = 65536;
   localparam int unsigned HDR_BYTES = 16;
   localparam int unsigned MIN_BYTES = 20;
   localparam int unsigned TRAILER_BYTES = 4;
   localparam int unsigned CMP_W = 18;
   localparam int unsigned QUEUE_DEPTH = 4;

   localparam logic [31:0] CRC_POLY = 32'hEDB88320;
   localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

   localparam logic [31:0] MAGIC_RESET = 32'h4D485558;
   localparam logic [15:0] VERSION_RESET = 16'h0100;
   localparam logic [15:0] MAX_LEN_RESET = 16'd65516;

   localparam logic [1:0] CSR_MAGIC = 2'd0;
   localparam logic [1:0] CSR_VERSION = 2'd1;
   localparam logic [1:0] CSR_MAX_LEN = 2'd2;

   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_VERDICT = 1'b1;

   typedef enum logic [2:0] {
      VERDICT_OK        = 3'd0,
      VERDICT_SHORT     = 3'd1,
      VERDICT_MAGIC     = 3'd2,
      VERDICT_VERSION   = 3'd3,
      VERDICT_LENGTH    = 3'd4,
      VERDICT_TRUNCATED = 3'd5,
      VERDICT_CRC       = 3'd6
   } verdict_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_buffer;
   } req_type;

   typedef struct packed {
      logic        result_kind;
      logic [7:0]  payload_byte;
      logic [2:0]  verdict;
      logic [15:0] frame_type;
      logic [15:0] frame_status;
      logic [31:0] sequence_number;
      logic [31:0] payload_length;
      logic [31:0] crc_received;
      logic [31:0] crc_computed;
      logic        last_result;
   } rsp_type;

   // One queue entry: what a single accepted byte asks the back end to emit.
   typedef struct packed {
      logic        has_payload;
      logic        has_verdict;
      logic [7:0]  payload_byte;
      verdict_type verdict;
      logic [15:0] frame_type;
      logic [15:0] frame_status;
      logic [31:0] sequence_number;
      logic [15:0] payload_length;
      logic [31:0] crc_received;
      logic [31:0] crc_computed;
   } cmd_type;

   typedef logic [31:0] crc_lut_type [256];

   function automatic crc_lut_type crc_build_lut();
      crc_lut_type tbl;
      logic [31:0] c;
      for (int i = 0; i < 256; i++) begin
         c = 32'(i);
         for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
         end
         tbl[i] = c;
      end
      return tbl;
   endfunction

   localparam crc_lut_type CRC_LUT = crc_build_lut();

   // Reflected CRC-32 update by one byte through the lookup table.
   function automatic logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
      return CRC_LUT[c[7:0] ^ b] ^ {8'h00, c[31:8]};
   endfunction

endpackage
`default_nettype wire

// File: sv/crcfd_front.sv
// Front end: accepts bytes, tracks framing, CRC and header, and builds queue entries.
`default_nettype none
module crcfd_front #(
   parameter int unsigned MAX_FRAME_BYTES = crcfd_pkg::MAX_FRAME_BYTES_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire crcfd_pkg::req_type   req_data,
   output logic                      req_stall,
   input  wire logic                 csr_write,
   input  wire logic [1:0]           csr_index,
   input  wire logic [31:0]          csr_wdata,
   input  wire logic                 queue_full,
   output logic                      push,
   output crcfd_pkg::cmd_type        cmd
);

   localparam int unsigned POS_W = $clog2(MAX_FRAME_BYTES + 1);
   localparam int unsigned CW = crcfd_pkg::CMP_W;

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [31:0]      crc_ff, crc_in;
   logic [31:0]      trailer_ff, trailer_in;
   logic             complete_ff, complete_in;
   logic [7:0]       header_ff [crcfd_pkg::HDR_BYTES];

   logic [31:0] magic_ff;
   logic [15:0] version_ff;
   logic [15:0] max_len_ff;

   logic        accept;
   logic [31:0] hdr_magic;
   logic [15:0] hdr_version;
   logic [15:0] hdr_len;
   logic [CW-1:0] pos_ext;
   logic [CW-1:0] pay_end;
   logic        in_range;
   logic        in_header;
   logic        in_payload;
   logic        in_trailer;
   logic        header_ok;
   logic [POS_W-1:0] count;
   logic [31:0] crc_calc;
   crcfd_pkg::verdict_type verdict;

   assign req_stall = queue_full;
   assign accept = req_valid & ~req_stall;

   assign hdr_magic = {header_ff[0], header_ff[1], header_ff[2], header_ff[3]};
   assign hdr_version = {header_ff[4], header_ff[5]};
   assign hdr_len = {header_ff[14], header_ff[15]};

   always_comb begin
      pos_ext = CW'(pos_ff);
      pay_end = CW'(crcfd_pkg::HDR_BYTES) + CW'(hdr_len);
      in_range = pos_ff < POS_W'(MAX_FRAME_BYTES);
      in_header = pos_ext < CW'(crcfd_pkg::HDR_BYTES);
      in_payload = !in_header && (pos_ext < pay_end);
      in_trailer = !in_header && !in_payload &&
                   (pos_ext < pay_end + CW'(crcfd_pkg::TRAILER_BYTES));
      header_ok = (hdr_magic == magic_ff) && (hdr_version == version_ff) &&
                  (hdr_len <= max_len_ff);

      crc_in = crc_ff;
      if (in_range && (in_header || in_payload)) begin
         crc_in = crcfd_pkg::crc_step(crc_ff, req_data.in_byte);
      end
      trailer_in = trailer_ff;
      complete_in = complete_ff;
      if (in_range && in_trailer) begin
         trailer_in = {trailer_ff[23:0], req_data.in_byte};
         if (pos_ext == pay_end + CW'(crcfd_pkg::TRAILER_BYTES - 1)) begin
            complete_in = 1'b1;
         end
      end
      count = in_range ? pos_ff + POS_W'(1) : pos_ff;
      crc_calc = ~crc_in;

      priority if (count < POS_W'(crcfd_pkg::MIN_BYTES)) begin
         verdict = crcfd_pkg::VERDICT_SHORT;
      end else if (hdr_magic != magic_ff) begin
         verdict = crcfd_pkg::VERDICT_MAGIC;
      end else if (hdr_version != version_ff) begin
         verdict = crcfd_pkg::VERDICT_VERSION;
      end else if (hdr_len > max_len_ff) begin
         verdict = crcfd_pkg::VERDICT_LENGTH;
      end else if (!complete_in) begin
         verdict = crcfd_pkg::VERDICT_TRUNCATED;
      end else if (trailer_in != crc_calc) begin
         verdict = crcfd_pkg::VERDICT_CRC;
      end else begin
         verdict = crcfd_pkg::VERDICT_OK;
      end

      cmd = '0;
      cmd.has_payload = in_range && in_payload && header_ok;
      cmd.has_verdict = req_data.end_of_buffer;
      cmd.payload_byte = req_data.in_byte;
      cmd.verdict = verdict;
      if (verdict != crcfd_pkg::VERDICT_SHORT) begin
         cmd.frame_type = {header_ff[6], header_ff[7]};
         cmd.frame_status = {header_ff[8], header_ff[9]};
         cmd.sequence_number = {header_ff[10], header_ff[11], header_ff[12], header_ff[13]};
         cmd.payload_length = hdr_len;
      end
      if (verdict == crcfd_pkg::VERDICT_OK || verdict == crcfd_pkg::VERDICT_CRC) begin
         cmd.crc_received = trailer_in;
         cmd.crc_computed = crc_calc;
      end
      push = accept && (cmd.has_payload || cmd.has_verdict);
      pos_in = count;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         crc_ff <= crcfd_pkg::CRC_INIT;
         trailer_ff <= '0;
         complete_ff <= 1'b0;
      end else if (accept) begin
         if (req_data.end_of_buffer) begin
            pos_ff <= '0;
            crc_ff <= crcfd_pkg::CRC_INIT;
            trailer_ff <= '0;
            complete_ff <= 1'b0;
         end else begin
            pos_ff <= pos_in;
            crc_ff <= crc_in;
            trailer_ff <= trailer_in;
            complete_ff <= complete_in;
         end
      end
   end

   // The header bytes are only read once the whole header has arrived.
   always_ff @(posedge clock) begin
      if (accept && in_range && in_header) begin
         header_ff[pos_ff[3:0]] <= req_data.in_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_ff <= crcfd_pkg::MAGIC_RESET;
         version_ff <= crcfd_pkg::VERSION_RESET;
         max_len_ff <= crcfd_pkg::MAX_LEN_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            crcfd_pkg::CSR_MAGIC:   magic_ff <= csr_wdata;
            crcfd_pkg::CSR_VERSION: version_ff <= csr_wdata[15:0];
            crcfd_pkg::CSR_MAX_LEN: max_len_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

endmodule
`default_nettype wire

// File: sv/crcfd_back.sv
// Back end: entry queue and output register that expands entries into result items.
`default_nettype none
module crcfd_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire crcfd_pkg::cmd_type  cmd,
   output logic                     queue_full,
   output logic                     rsp_valid,
   output crcfd_pkg::rsp_type       rsp_data,
   input  wire logic                rsp_stall
);

   localparam int unsigned DEPTH = crcfd_pkg::QUEUE_DEPTH;
   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   crcfd_pkg::cmd_type queue_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             split_ff, split_in;
   logic             rsp_valid_ff, rsp_valid_in;
   crcfd_pkg::rsp_type rsp_data_ff, rsp_data_in;

   crcfd_pkg::cmd_type head;
   crcfd_pkg::rsp_type payload_rsp;
   crcfd_pkg::rsp_type verdict_rsp;
   logic load;
   logic pop;

   assign queue_full = count_ff == CNT_W'(DEPTH);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   always_comb begin
      head = queue_ff[rd_ptr_ff];

      payload_rsp = '0;
      payload_rsp.result_kind = crcfd_pkg::KIND_PAYLOAD;
      payload_rsp.payload_byte = head.payload_byte;

      verdict_rsp = '0;
      verdict_rsp.result_kind = crcfd_pkg::KIND_VERDICT;
      verdict_rsp.verdict = head.verdict;
      verdict_rsp.frame_type = head.frame_type;
      verdict_rsp.frame_status = head.frame_status;
      verdict_rsp.sequence_number = head.sequence_number;
      verdict_rsp.payload_length = 32'(head.payload_length);
      verdict_rsp.crc_received = head.crc_received;
      verdict_rsp.crc_computed = head.crc_computed;
      verdict_rsp.last_result = 1'b1;

      load = (count_ff != '0) && (!rsp_valid_ff || !rsp_stall);
      // An entry carrying both a payload byte and a verdict is emitted in two turns.
      pop = load && !(head.has_payload && head.has_verdict && !split_ff);
      split_in = load ? !pop : split_ff;

      rsp_valid_in = load || (rsp_valid_ff && rsp_stall);
      rsp_data_in = rsp_data_ff;
      if (load) begin
         rsp_data_in = (head.has_payload && !split_ff) ? payload_rsp : verdict_rsp;
      end

      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
         split_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
         split_ff <= split_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (push) begin
         queue_ff[wr_ptr_ff] <= cmd;
      end
   end

endmodule
`default_nettype wire

// File: sv/crc_framed_packet_deframer.sv
// A result item passes through the queue and then the output register before it appears on rsp.
// Throughput: one byte per cycle while the queue is not full; the front end does one table CRC update per byte.
// A last byte that also carries payload yields two result items, the payload byte first and then the verdict.
// A four-entry queue between front and back end absorbs result-side stalls.
// Reset clears framing state, queue and output valid, and restores register defaults.
`default_nettype none
module crc_framed_packet_deframer #(
   parameter int unsigned MAX_FRAME_BYTES = crcfd_pkg::MAX_FRAME_BYTES_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   input  wire crcfd_pkg::req_type  req_data,
   output logic                     req_stall,
   output logic                     rsp_valid,
   output crcfd_pkg::rsp_type       rsp_data,
   input  wire logic                rsp_stall,
   input  wire logic                csr_write,
   input  wire logic [1:0]          csr_index,
   input  wire logic [31:0]         csr_wdata
);

   logic               queue_full;
   logic               push;
   crcfd_pkg::cmd_type cmd;

   crcfd_front #(
      .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_data(req_data),
      .req_stall(req_stall),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .queue_full(queue_full),
      .push(push),
      .cmd(cmd)
   );

   crcfd_back u_back (
      .clock(clock),
      .reset(reset),
      .push(push),
      .cmd(cmd),
      .queue_full(queue_full),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data),
      .rsp_stall(rsp_stall)
   );

endmodule
`default_nettype wire

// File: sv/crcfd_checker.sv
// Port-level checks on the deframer result channel, bound to the top level.
`default_nettype none
`include "crc_framed_packet_deframer_defines.svh"
module crcfd_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               rsp_valid,
   input wire logic               rsp_stall,
   input wire crcfd_pkg::rsp_type rsp_data
);

   logic is_payload;
   logic is_verdict;
   logic is_short;
   logic rsp_waiting;
   logic payload_clean;
   logic verdict_marked;
   logic short_clean;

   assign is_payload = rsp_valid && (rsp_data.result_kind == crcfd_pkg::KIND_PAYLOAD);
   assign is_verdict = rsp_valid && (rsp_data.result_kind == crcfd_pkg::KIND_VERDICT);
   assign is_short = is_verdict && (rsp_data.verdict == crcfd_pkg::VERDICT_SHORT);
   assign rsp_waiting = rsp_valid && rsp_stall;
   assign payload_clean = !rsp_data.last_result &&
                          (rsp_data.verdict == crcfd_pkg::VERDICT_OK) &&
                          (rsp_data.crc_computed == '0) && (rsp_data.payload_length == '0);
   assign verdict_marked = rsp_data.last_result && (rsp_data.verdict <= crcfd_pkg::VERDICT_CRC);
   assign short_clean = (rsp_data.sequence_number == '0) && (rsp_data.payload_length == '0) &&
                        (rsp_data.crc_received == '0);

   `CRCFD_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_waiting, rsp_valid && $stable(rsp_data))
   `CRCFD_ASSERT_IMP(a_payload_clean, clock, reset, is_payload, payload_clean)
   `CRCFD_ASSERT_IMP(a_verdict_last, clock, reset, is_verdict, verdict_marked)
   `CRCFD_ASSERT_IMP(a_short_no_fields, clock, reset, is_short, short_clean)

endmodule

bind crc_framed_packet_deframer crcfd_checker u_checker (
   .clock(clock),
   .reset(reset),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_data(rsp_data)
);
`default_nettype wire
